// ----- rtl/core/sparse_polynomial_term_store_core_defines.svh -----
// ----------------------------------------------------------------------------
// sparse_polynomial_term_store_core_defines
// Assertion helpers for the term store.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_TERM_STORE_CORE_DEFINES_SVH
`define SPARSE_POLYNOMIAL_TERM_STORE_CORE_DEFINES_SVH

// Implication checked on every clock edge once reset is released.
`define SPTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked on every clock edge once reset is released.
`define SPTS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ----- rtl/core/spts_pkg.sv -----
// ----------------------------------------------------------------------------
// spts_pkg
// Shared types and codes of the sparse polynomial term store.
// ----------------------------------------------------------------------------
package spts_pkg;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [15:0] expo;
		logic signed [31:0] coef;
	} term_t;

endpackage

// ----- rtl/core/spts_ram.sv -----
// ----------------------------------------------------------------------------
// spts_ram
// Term table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spts_ram #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  spts_pkg::term_t            wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output spts_pkg::term_t            rdata
);
	import spts_pkg::*;

	term_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/sparse_polynomial_term_store_core.sv -----
// Add scans the table, then shifts entries up to insert or down to close a cancelled gap.
// Throughput: one item at a time; the scan and shift run over the single table RAM port pair.
// Reset (arst_n low, asynchronous): term count zero, output empty; table contents undefined.
// Output register lets the next item start while a result waits.
// ----------------------------------------------------------------------------
// sparse_polynomial_term_store_core
// Sorted sparse polynomial term table held in one RAM, with a sequencer.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_store_core #(
	parameter int MAX_TERMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [15:0] exponent,
	input  logic signed [31:0] coefficient,
	input  logic [5:0]         index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [6:0]         term_count,
	output logic               is_empty,
	output logic signed [15:0] degree,
	output logic signed [15:0] read_exponent,
	output logic signed [31:0] read_coefficient
);
	import spts_pkg::*;
	`include "sparse_polynomial_term_store_core_defines.svh"

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_TERMS);

	// sequencer states
	typedef enum logic [6:0] {
		IDLE = 7'b0000001,
		SCAN = 7'b0000010,
		SHUP = 7'b0000100,
		INS  = 7'b0001000,
		SHDN = 7'b0010000,
		RD   = 7'b0100000,
		DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, ptr_q, ptr_d, pos_q, pos_d;
	logic [CW-1:0] ptr_p1, ptr_p2, ptr_m1, ptr_m2, cnt_m1;
	logic signed [15:0] deg_q, deg_d, e_q;
	logic signed [31:0] c_q;
	logic [1:0] st_q, st_d;
	logic signed [15:0] rexp_q, rexp_d;
	logic signed [31:0] rcoef_q, rcoef_d;

	logic we;
	logic [AW-1:0] waddr, raddr;
	term_t wdata, rd;
	logic signed [32:0] sum;
	logic signed [31:0] sum_sat;
	logic sum_ovf;

	spts_ram #(.DEPTH(MAX_TERMS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign in_ready = (state_q == IDLE);

	assign ptr_p1 = ptr_q + CW'(1);
	assign ptr_p2 = ptr_q + CW'(2);
	assign ptr_m1 = ptr_q - CW'(1);
	assign ptr_m2 = ptr_q - CW'(2);
	assign cnt_m1 = cnt_q - CW'(1);

	// merge sum, saturated to Q16.16
	assign sum     = {rd.coef[31], rd.coef} + {c_q[31], c_q};
	assign sum_ovf = (sum[32] != sum[31]);
	assign sum_sat = sum_ovf ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ptr_d   = ptr_q;
		pos_d   = pos_q;
		deg_d   = deg_q;
		st_d    = st_q;
		rexp_d  = rexp_q;
		rcoef_d = rcoef_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '{expo: e_q, coef: c_q};
		raddr   = '0;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					st_d    = ST_OK;
					rexp_d  = '0;
					rcoef_d = '0;
					state_d = DONE;
					unique case (command)
						CMD_ADD: begin
							if (coefficient == 32'sd0) begin
								state_d = DONE;
							end else if (cnt_q == '0) begin
								// empty table: straight write at the top
								we      = 1'b1;
								wdata   = '{expo: exponent, coef: coefficient};
								cnt_d   = CW'(1);
								deg_d   = exponent;
							end else begin
								ptr_d   = '0;
								state_d = SCAN;
							end
						end
						CMD_CLEAR: cnt_d = '0;
						CMD_READ: begin
							if (32'(index) < 32'(cnt_q)) begin
								raddr   = AW'(index);
								state_d = RD;
							end else begin
								st_d = ST_RANGE;
							end
						end
						default: state_d = DONE;
					endcase
				end
			end
			SCAN: begin
				if (rd.expo > e_q) begin
					if (ptr_p1 == cnt_q) begin
						// belongs after the last term
						if (cnt_q == MAXC) begin
							st_d = ST_FULL;
						end else begin
							we    = 1'b1;
							waddr = cnt_q[AW-1:0];
							cnt_d = cnt_q + CW'(1);
						end
						state_d = DONE;
					end else begin
						ptr_d = ptr_p1;
						raddr = ptr_p1[AW-1:0];
					end
				end else if (rd.expo == e_q) begin
					st_d = sum_ovf ? ST_SAT : ST_OK;
					if (sum_sat == 32'sd0) begin
						if (ptr_p1 == cnt_q) begin
							cnt_d   = cnt_m1;
							state_d = DONE;
						end else begin
							raddr   = ptr_p1[AW-1:0];
							state_d = SHDN;
						end
					end else begin
						we      = 1'b1;
						waddr   = ptr_q[AW-1:0];
						wdata   = '{expo: e_q, coef: sum_sat};
						state_d = DONE;
					end
				end else begin
					if (cnt_q == MAXC) begin
						st_d    = ST_FULL;
						state_d = DONE;
					end else begin
						pos_d   = ptr_q;
						ptr_d   = cnt_q;
						raddr   = cnt_m1[AW-1:0];
						state_d = SHUP;
					end
				end
			end
			SHUP: begin
				// move entry ptr-1 up to ptr
				we    = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = rd;
				if (ptr_m1 == pos_q) begin
					state_d = INS;
				end else begin
					ptr_d = ptr_m1;
					raddr = ptr_m2[AW-1:0];
				end
			end
			INS: begin
				we      = 1'b1;
				waddr   = pos_q[AW-1:0];
				cnt_d   = cnt_q + CW'(1);
				if (pos_q == '0) begin
					deg_d = e_q;
				end
				state_d = DONE;
			end
			SHDN: begin
				// move entry ptr+1 down to ptr
				we    = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = rd;
				if (ptr_q == '0) begin
					deg_d = rd.expo;
				end
				if (ptr_p2 == cnt_q) begin
					cnt_d   = cnt_m1;
					state_d = DONE;
				end else begin
					ptr_d = ptr_p1;
					raddr = ptr_p2[AW-1:0];
				end
			end
			RD: begin
				rexp_d  = rd.expo;
				rcoef_d = rd.coef;
				state_d = DONE;
			end
			DONE: begin
				if (!out_valid || out_ready) begin
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		pos_q   <= pos_d;
		deg_q   <= deg_d;
		st_q    <= st_d;
		rexp_q  <= rexp_d;
		rcoef_q <= rcoef_d;
		if (in_valid && in_ready) begin
			e_q <= exponent;
			c_q <= coefficient;
		end
	end

	// output register: holds one result while the next item is worked on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == DONE && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DONE && (!out_valid || out_ready)) begin
			status           <= st_q;
			term_count       <= 7'(cnt_q);
			is_empty         <= (cnt_q == '0);
			degree           <= (cnt_q == '0) ? 16'sd0 : deg_q;
			read_exponent    <= rexp_q;
			read_coefficient <= rcoef_q;
		end
	end

	`SPTS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= MAXC, "term count above table size")
	`SPTS_ASSERT_IMP(a_idle_no_write, state_q == IDLE && !in_valid, !we, "table write while idle")
	`SPTS_ASSERT_IMP(a_full_status, state_q == DONE && st_q == ST_FULL, cnt_q == MAXC,
		"full status with free entries")
	`SPTS_ASSERT_IMP(a_shup_order, state_q == SHUP, ptr_q > pos_q && ptr_q <= cnt_q,
		"shift pointer out of range")

endmodule

// ----- tb/tb_sparse_polynomial_term_store_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_term_store_core
// Drives add, clear and read commands into the sorted term table and checks
// every result against a behavioural copy of the table kept in the bench.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_term_store_core;
	import spts_pkg::*;

	localparam int TERMS_MAX = 64;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic signed [15:0] exponent;
	logic signed [31:0] coefficient;
	logic [5:0]         index;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [6:0]         term_count;
	logic               is_empty;
	logic signed [15:0] degree;
	logic signed [15:0] read_exponent;
	logic signed [31:0] read_coefficient;

	// one expected result per transfer
	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         count;
		logic               empty;
		logic signed [15:0] degree;
		logic signed [15:0] rd_expo;
		logic signed [31:0] rd_coef;
	} outcome_t;

	// bench copy of the term table, descending exponent order
	term_t    poly_terms[TERMS_MAX];
	int       poly_len;
	outcome_t pending_outcomes[$];

	int errors;
	int items_sent;
	int results_seen;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;

	sparse_polynomial_term_store_core #(.MAX_TERMS(TERMS_MAX)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .exponent(exponent),
		.coefficient(coefficient), .index(index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .term_count(term_count), .is_empty(is_empty),
		.degree(degree), .read_exponent(read_exponent),
		.read_coefficient(read_coefficient)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Work out the result of one command and update the bench table.
	function automatic outcome_t merge_term(logic [1:0] cmd, logic signed [15:0] e,
			logic signed [31:0] c, logic [5:0] idx);
		outcome_t   o;
		int         pos;
		longint     sum;
		o = '0;
		o.status = ST_OK;
		if (cmd == CMD_ADD && c != 0) begin
			pos = 0;
			while (pos < poly_len && poly_terms[pos].expo > e)
				pos++;
			if (pos < poly_len && poly_terms[pos].expo == e) begin
				sum = longint'(poly_terms[pos].coef) + longint'(c);
				if (sum > longint'(Q_MAX)) begin
					sum = longint'(Q_MAX);
					o.status = ST_SAT;
				end
				if (sum < longint'(Q_MIN)) begin
					sum = longint'(Q_MIN);
					o.status = ST_SAT;
				end
				if (sum == 0) begin
					// cancelled term: close the gap
					for (int k = pos; k + 1 < poly_len; k++)
						poly_terms[k] = poly_terms[k + 1];
					poly_len--;
				end else begin
					poly_terms[pos].coef = sum[31:0];
				end
			end else if (poly_len >= TERMS_MAX) begin
				o.status = ST_FULL;
			end else begin
				for (int k = poly_len; k > pos; k--)
					poly_terms[k] = poly_terms[k - 1];
				poly_terms[pos].expo = e;
				poly_terms[pos].coef = c;
				poly_len++;
			end
		end else if (cmd == CMD_CLEAR) begin
			poly_len = 0;
		end else if (cmd == CMD_READ) begin
			if (idx < poly_len) begin
				o.rd_expo = poly_terms[idx].expo;
				o.rd_coef = poly_terms[idx].coef;
			end else begin
				o.status = ST_RANGE;
			end
		end
		o.count  = poly_len[6:0];
		o.empty  = (poly_len == 0);
		o.degree = (poly_len > 0) ? poly_terms[0].expo : 16'sd0;
		return o;
	endfunction

	// Offer one command, with a random idle gap first, and wait for the transfer.
	// Valid stays high after the transfer until the next command or an idle gap.
	task automatic send_command(logic [1:0] cmd, logic signed [15:0] e,
			logic signed [31:0] c, logic [5:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		exponent    <= e;
		coefficient <= c;
		index       <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_outcomes.insert(pending_outcomes.size(), merge_term(cmd, e, c, idx));
		items_sent++;
	endtask

	task automatic add_term(logic signed [15:0] e, logic signed [31:0] c);
		send_command(CMD_ADD, e, c, 6'd0);
	endtask

	task automatic read_term(logic [5:0] idx);
		send_command(CMD_READ, 16'($urandom()), 32'($urandom()), idx);
	endtask

	task automatic clear_poly();
		send_command(CMD_CLEAR, 16'($urandom()), 32'($urandom()), 6'($urandom()));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off when hold_cycles is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				exp_o = pending_outcomes.pop_front();
				if (status !== exp_o.status) begin
					$error("status exp %0d got %0d", exp_o.status, status);
					errors++;
				end
				if (term_count !== exp_o.count) begin
					$error("term_count exp %0d got %0d", exp_o.count, term_count);
					errors++;
				end
				if (is_empty !== exp_o.empty) begin
					$error("is_empty exp %0d got %0d", exp_o.empty, is_empty);
					errors++;
				end
				if (degree !== exp_o.degree) begin
					$error("degree exp %0d got %0d", exp_o.degree, degree);
					errors++;
				end
				if (read_exponent !== exp_o.rd_expo) begin
					$error("read_exponent exp %0d got %0d", exp_o.rd_expo, read_exponent);
					errors++;
				end
				if (read_coefficient !== exp_o.rd_coef) begin
					$error("read_coefficient exp %0d got %0d", exp_o.rd_coef,
						read_coefficient);
					errors++;
				end
			end
		end
	end

	// Edge values: extreme exponents and coefficients, every command, ignored
	// zero add, cancellation, saturation both ways, reads past the end, the
	// unused command code.
	task automatic test_directed();
		add_term(16'sh7FFF, 32'sh0001_0000);
		add_term(-16'sh8000, Q_MIN);
		add_term(16'sd0, 32'sd0);
		add_term(16'sd5, Q_MAX);
		add_term(16'sd5, 32'sd1);
		add_term(-16'sh8000, -32'sd1);
		add_term(16'sh7FFF, -32'sh0001_0000);
		read_term(6'd0);
		read_term(6'd1);
		read_term(6'd2);
		read_term(6'd63);
		send_command(CMD_UNUSED, 16'sh7FFF, 32'shFFFF_FFFF, 6'h3F);
		clear_poly();
		read_term(6'd0);
		add_term(16'sd3, 32'sh7FFF_FFFF);
		add_term(16'sd3, 32'sh8000_0001);
		read_term(6'd0);
		drain_results();
	endtask

	// Fill all 64 slots, then hit full-table drops, merges and reads at both ends.
	task automatic test_full_table();
		clear_poly();
		for (int i = 0; i < TERMS_MAX; i++)
			add_term(16'(i * 3 - 90), 32'($urandom_range(1000, 1)));
		add_term(16'sd1, 32'sd7);
		add_term(16'sd0, 32'sd7);
		read_term(6'd63);
		read_term(6'd0);
		add_term(-16'sd90, -32'sd1);
		drain_results();
	endtask

	// Random traffic: mostly adds on a narrow exponent set so merges and
	// cancellations happen, with reads and occasional clears mixed in.
	task automatic test_random(int n);
		int sel;
		logic signed [15:0] e;
		logic signed [31:0] c;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 2) begin
				clear_poly();
			end else if (sel < 30) begin
				read_term(6'($urandom_range(poly_len < 63 ? poly_len + 1 : 63)));
			end else if (sel < 34) begin
				send_command(CMD_UNUSED, 16'($urandom()), 32'($urandom()),
					6'($urandom()));
			end else begin
				e = ($urandom_range(9) == 0) ? 16'($urandom()) :
					16'(int'($urandom_range(80)) - 40);
				case ($urandom_range(5))
					0: c = $urandom();
					1: c = (poly_len > 0 && $urandom_range(1)) ?
						-poly_terms[$urandom_range(poly_len - 1)].coef : 32'sd0;
					2: c = $urandom_range(1) ? Q_MAX : Q_MIN;
					default: c = 32'(int'($urandom_range(2000)) - 1000) <<< 8;
				endcase
				add_term(e, c);
			end
		end
		drain_results();
	endtask

	// Hold the receiver off for a long stretch while commands keep coming.
	task automatic test_backpressure();
		hold_cycles <= 200;
		for (int i = 0; i < 12; i++)
			read_term(6'($urandom_range(63)));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_ADD;
		exponent = '0;
		coefficient = '0;
		index = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		poly_len = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_backpressure();
		test_random(212);
		send_idle_pct = 54;
		test_random(212);
		send_idle_pct = 0;
		recv_stall_pct = 54;
		test_random(212);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		test_random(212);

		$display("Covered %0d commands and %0d results: adds, merges, cancels,",
			items_sent, results_seen);
		$display("saturation, full-table drops, reads in and out of range, clears.");
		if (errors == 0)
			$display("tb_sparse_polynomial_term_store_core OK");
		else
			$display("tb_sparse_polynomial_term_store_core NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_sparse_polynomial_term_store_core NOT OK");
		$finish;
	end

endmodule
